### rtl/xyc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xyc_pkg;

  typedef struct packed {
    logic [15:0] chroma_x;
    logic [15:0] chroma_y;
  } xyc_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       y_zero;
  } xyc_out_t;

  localparam int CoefW = 20;
  localparam int ChW   = 34;
  localparam int AccW  = 56;

  // XYZ to RGB matrix, signed Q4.16
  localparam logic signed [CoefW-1:0] XYZ2RGB [0:2][0:2] = '{
    '{ 20'sd90598,  -20'sd10987, -20'sd13660},
    '{-20'sd52663,   20'sd115432,  20'sd2685},
    '{ 20'sd1747,   -20'sd6018,   20'sd67754}
  };

  localparam logic signed [AccW-1:0] ChMax = 56'sd8589934591;
  localparam logic signed [AccW-1:0] ChMin = -56'sd8589934592;
  localparam logic signed [ChW-1:0]  OneQ16 = 34'sd65536;

endpackage

`default_nettype wire

### rtl/xy_chromaticity_to_rgb_core.sv
// Channel  Ports                     Handshake
// request  start, busy, in_req       taken when start && !busy
// result   out_strobe, out_res       one cycle, strobe high, no back-pressure
//
// One request per cycle while busy is low.
// The pipeline holds the two 32-step pipelined dividers for X and Z and the
// 17-step pipelined normalizing divider.
// busy is high only while rst_n is low and in the cycle after.
// The pipeline never stalls: the receiver must take every strobe, which the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module xy_chromaticity_to_rgb_core import xyc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire xyc_in_t  in_req,
  output logic          out_strobe,
  output xyc_out_t      out_res
);

  localparam int DivN = 32;
  localparam int NrmN = 17;
  localparam int Lat  = DivN + NrmN + 6;

  logic busy_r;
  logic accept;
  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end

  // ---------------- stage 0: numerators ----------------
  logic signed [17:0] zs;
  logic               zneg_in;
  logic [17:0]        zmag;
  assign zs      = 18'sd65535 - $signed({2'b00, in_req.chroma_x})
                   - $signed({2'b00, in_req.chroma_y});
  assign zneg_in = zs[17];
  assign zmag    = zneg_in ? 18'(-zs) : 18'(zs);

  logic [DivN:0]  dv_r;
  logic [31:0]    dx_r [0:DivN];
  logic [31:0]    dz_r [0:DivN];
  logic [15:0]    rx_r [0:DivN];
  logic [15:0]    rz_r [0:DivN];
  logic [31:0]    qx_r [0:DivN];
  logic [31:0]    qz_r [0:DivN];
  logic [15:0]    dy_r [0:DivN];
  logic [DivN:0]  zn_r;
  logic [DivN:0]  yz0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= accept;
    dx_r[0]  <= {in_req.chroma_x, 16'h0000};
    dz_r[0]  <= {zmag[15:0], 16'h0000};
    rx_r[0]  <= '0;
    rz_r[0]  <= '0;
    qx_r[0]  <= '0;
    qz_r[0]  <= '0;
    dy_r[0]  <= in_req.chroma_y;
    zn_r[0]  <= zneg_in;
    yz0_r[0] <= (in_req.chroma_y == 16'h0000);
  end

  // ---------------- X and |Z| dividers, one bit per stage ----------------
  for (genvar k = 0; k < DivN; k++) begin : g_div
    logic [16:0] tx, tz;
    logic        gx, gz;
    assign tx = {rx_r[k], dx_r[k][31]};
    assign tz = {rz_r[k], dz_r[k][31]};
    assign gx = tx >= {1'b0, dy_r[k]};
    assign gz = tz >= {1'b0, dy_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
      dx_r[k+1]  <= {dx_r[k][30:0], 1'b0};
      dz_r[k+1]  <= {dz_r[k][30:0], 1'b0};
      rx_r[k+1]  <= gx ? 16'(tx - {1'b0, dy_r[k]}) : tx[15:0];
      rz_r[k+1]  <= gz ? 16'(tz - {1'b0, dy_r[k]}) : tz[15:0];
      qx_r[k+1]  <= {qx_r[k][30:0], gx};
      qz_r[k+1]  <= {qz_r[k][30:0], gz};
      dy_r[k+1]  <= dy_r[k];
      zn_r[k+1]  <= zn_r[k];
      yz0_r[k+1] <= yz0_r[k];
    end
  end

  // ---------------- matrix products ----------------
  logic signed [ChW-1:0] opx, opz, opzm;
  assign opx  = $signed({2'b00, qx_r[DivN]});
  assign opzm = $signed({2'b00, qz_r[DivN]});
  assign opz  = zn_r[DivN] ? -opzm : opzm;

  logic signed [AccW-1:0] px_r [0:2];
  logic signed [AccW-1:0] pz_r [0:2];
  logic signed [AccW-1:0] acc_r [0:2];
  logic signed [ChW-1:0]  ch_r [0:2];
  logic                   mv_r, av_r, tv_r;
  logic                   myz_r, ayz_r, tyz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      av_r <= 1'b0;
      tv_r <= 1'b0;
    end else begin
      mv_r <= dv_r[DivN];
      av_r <= mv_r;
      tv_r <= av_r;
    end
    myz_r <= yz0_r[DivN];
    ayz_r <= myz_r;
    tyz_r <= ayz_r;
  end

  for (genvar i = 0; i < 3; i++) begin : g_mat
    logic signed [AccW-1:0] cy_term, sum, adj, sh;
    assign cy_term = AccW'($signed(XYZ2RGB[i][1])) <<< 16;
    assign sum     = px_r[i] + pz_r[i] + cy_term;
    // truncate toward zero on the shift
    assign adj     = acc_r[i] + (acc_r[i][AccW-1] ? 56'sd65535 : 56'sd0);
    assign sh      = adj >>> 16;

    always_ff @(posedge clk) begin
      px_r[i]  <= AccW'($signed(XYZ2RGB[i][0]) * opx);
      pz_r[i]  <= AccW'($signed(XYZ2RGB[i][2]) * opz);
      acc_r[i] <= sum;
      if (sh > ChMax)      ch_r[i] <= ChMax[ChW-1:0];
      else if (sh < ChMin) ch_r[i] <= ChMin[ChW-1:0];
      else                 ch_r[i] <= sh[ChW-1:0];
    end
  end

  // ---------------- max, clamp, normalize setup ----------------
  logic signed [ChW-1:0] mx01, mx;
  assign mx01 = (ch_r[1] > ch_r[0]) ? ch_r[1] : ch_r[0];
  assign mx   = (ch_r[2] > mx01) ? ch_r[2] : mx01;

  logic [NrmN:0]  nv_r;
  logic [NrmN:0]  nyz_r;
  logic [NrmN:0]  nrm_r;
  logic [32:0]    nmx_r [0:NrmN];
  logic [34:0]    nrem_r [0:NrmN][0:2];
  logic [16:0]    nq_r   [0:NrmN][0:2];
  logic [16:0]    ncl_r  [0:NrmN][0:2];
  logic           nneg_r [0:NrmN][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r[0] <= 1'b0;
    else        nv_r[0] <= tv_r;
    nyz_r[0] <= tyz_r;
    nrm_r[0] <= mx > OneQ16;
    nmx_r[0] <= mx[32:0];
  end

  for (genvar i = 0; i < 3; i++) begin : g_cl
    logic neg;
    assign neg = ch_r[i][ChW-1];
    always_ff @(posedge clk) begin
      nneg_r[0][i] <= neg;
      nq_r[0][i]   <= '0;
      nrem_r[0][i] <= neg ? 35'd0 : {2'b00, ch_r[i][32:0]};
      if (neg)                  ncl_r[0][i] <= '0;
      else if (ch_r[i] > OneQ16) ncl_r[0][i] <= 17'h10000;
      else                      ncl_r[0][i] <= ch_r[i][16:0];
    end
  end

  // ---------------- normalizing divider: ch * 2^16 / max ----------------
  for (genvar j = 0; j < NrmN; j++) begin : g_nrm
    always_ff @(posedge clk) begin
      if (!rst_n) nv_r[j+1] <= 1'b0;
      else        nv_r[j+1] <= nv_r[j];
      nyz_r[j+1] <= nyz_r[j];
      nrm_r[j+1] <= nrm_r[j];
      nmx_r[j+1] <= nmx_r[j];
    end

    for (genvar i = 0; i < 3; i++) begin : g_ch
      logic [34:0] t;
      logic        ge;
      // first step checks the integer bit, the rest shift in fraction bits
      assign t  = (j == 0) ? nrem_r[j][i] : {nrem_r[j][i][33:0], 1'b0};
      assign ge = t >= {2'b00, nmx_r[j]};
      always_ff @(posedge clk) begin
        nrem_r[j+1][i] <= ge ? 35'(t - {2'b00, nmx_r[j]}) : t;
        nq_r[j+1][i]   <= {nq_r[j][i][15:0], ge};
        ncl_r[j+1][i]  <= ncl_r[j][i];
        nneg_r[j+1][i] <= nneg_r[j][i];
      end
    end
  end

  // ---------------- scale by 255 and output ----------------
  logic [7:0] chan [0:2];
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [16:0] v;
    logic [24:0] p;
    assign v = nrm_r[NrmN] ? (nneg_r[NrmN][i] ? 17'd0 : nq_r[NrmN][i])
                           : ncl_r[NrmN][i];
    assign p = {v, 8'h00} - {8'h00, v};
    assign chan[i] = nyz_r[NrmN] ? 8'h00 : p[23:16];
  end

  logic     out_strobe_r;
  xyc_out_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= nv_r[NrmN];
    out_res_r.red    <= chan[0];
    out_res_r.green  <= chan[1];
    out_res_r.blue   <= chan[2];
    out_res_r.y_zero <= nyz_r[NrmN];
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##Lat out_strobe)
    else $error("request did not produce a result at the expected latency");

  a_yzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.y_zero |->
      (out_res.red == 8'h00) && (out_res.green == 8'h00) && (out_res.blue == 8'h00))
    else $error("zero y result carries nonzero color");

  a_busy: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  a_nrm_max: assert property (@(posedge clk) disable iff (!rst_n)
    nv_r[NrmN] && nrm_r[NrmN] && !nyz_r[NrmN] |->
      (nq_r[NrmN][0] == 17'h10000) || (nq_r[NrmN][1] == 17'h10000)
      || (nq_r[NrmN][2] == 17'h10000))
    else $error("normalized result has no channel at full scale");

endmodule

`default_nettype wire
